@@ design/ccbp_pkg.sv @@
package ccbp_pkg;

    // Field and register widths
    localparam int DATA_W        = 8;
    localparam int CFG_DATA_W    = 16;
    localparam int CFG_INDEX_W   = 2;
    localparam int GEN_W         = 4;
    localparam int FRAME_LEN_W   = 16;

    // Default frame counter width
    localparam int FRAME_COUNT_BITS_DEF = 16;

    // Code bits per input byte in each word mode
    localparam int CODE_BITS_BYTE   = 11;
    localparam int CODE_BITS_NIBBLE = 14;
    localparam int HEADER_BITS      = 8;
    localparam int PAD_W            = 3;

    // Largest bit run one input byte can add: header, padding, nibble codes
    localparam int CHUNK_BITS = HEADER_BITS + (1 << PAD_W) - 1 + CODE_BITS_NIBBLE;
    localparam int CNT_W      = $clog2(CHUNK_BITS + 1);

    // Word queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Register reset values
    localparam logic [GEN_W-1:0]       GEN_RESET       = 4'd11;
    localparam logic                   WORD_MODE_RESET = 1'b1;
    localparam logic [FRAME_LEN_W-1:0] FRAME_LEN_RESET = 16'd1;

    // Word mode codes
    localparam logic MODE_NIBBLE = 1'b0;
    localparam logic MODE_BYTE   = 1'b1;

    // Register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_GENERATOR    = 2'd0,
        REG_WORD_MODE    = 2'd1,
        REG_FRAME_LENGTH = 2'd2
    } cfg_index_t;

    // One run of code bits handed from front to back
    typedef struct packed {
        logic [CHUNK_BITS-1:0] bits;
        logic [CNT_W-1:0]      nbits;
        logic                  frame_end;
    } chunk_t;

    // CRC remainder of an 8-bit word times x^3, generator top bit implied
    function automatic logic [2:0] crc_rem8(input logic [7:0] d, input logic [2:0] g);
        logic [2:0] r;
        logic       fb;
        r = '0;
        for (int i = 7; i >= 0; i--) begin
            fb = r[2] ^ d[i];
            r  = {r[1:0], 1'b0} ^ (fb ? g : 3'b000);
        end
        return r;
    endfunction

    // CRC remainder of a 4-bit word times x^3
    function automatic logic [2:0] crc_rem4(input logic [3:0] d, input logic [2:0] g);
        logic [2:0] r;
        logic       fb;
        r = '0;
        for (int i = 3; i >= 0; i--) begin
            fb = r[2] ^ d[i];
            r  = {r[1:0], 1'b0} ^ (fb ? g : 3'b000);
        end
        return r;
    endfunction

endpackage

@@ design/ccbp_queue.sv @@
module ccbp_queue
    import ccbp_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   wr_en,
    input  chunk_t wr_data,
    input  logic   rd_en,
    output chunk_t rd_data,
    output logic   q_full,
    output logic   q_empty
);

    chunk_t                 mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]      wr_ptr_reg;
    logic [QPTR_W-1:0]      rd_ptr_reg;
    logic [QPTR_W:0]        count_reg;
    logic [QPTR_W:0]        count_next;

    assign q_full  = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign q_empty = (count_reg == '0);
    assign rd_data = mem[rd_ptr_reg];

    // Track fill level
    always_comb
    begin
        count_next = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!wr_en && rd_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Store words
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    // Advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // Fill level stays in range
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (QPTR_W+1)'(QUEUE_DEPTH))
        else $error("queue count out of range");

endmodule

@@ design/ccbp_front.sv @@
module ccbp_front
    import ccbp_pkg::*;
#(
    parameter int FRAME_COUNT_BITS = FRAME_COUNT_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   accept,
    input  logic [DATA_W-1:0]      data_byte,
    output chunk_t                 chunk,
    output logic                   restart
);

    logic [GEN_W-1:0]            generator_reg;
    logic                        word_mode_reg;
    logic [FRAME_LEN_W-1:0]      frame_length_reg;
    logic [FRAME_COUNT_BITS-1:0] bytes_seen_reg;
    logic [FRAME_COUNT_BITS-1:0] bytes_seen_next;

    logic [FRAME_COUNT_BITS-1:0] len_masked;
    logic [FRAME_COUNT_BITS-1:0] len_eff;
    logic [PAD_W-1:0]            pad;
    logic                        frame_end;
    logic                        header;
    logic [2:0]                  gen_low;
    logic [CODE_BITS_NIBBLE-1:0] code;
    logic [CNT_W-1:0]            code_len;
    logic [CNT_W-1:0]            hdr_shift;
    logic [CHUNK_BITS-1:0]       hdr_word;

    // Decode register writes; a write to a listed register restarts the frame
    always_comb
    begin
        restart = 1'b0;
        if (cfg_wr_en)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_GENERATOR:    restart = 1'b1;
                REG_WORD_MODE:    restart = 1'b1;
                REG_FRAME_LENGTH: restart = 1'b1;
                default:          restart = 1'b0;
            endcase
        end
    end

    // Effective frame length and padding count
    assign len_masked = FRAME_COUNT_BITS'(frame_length_reg);
    assign len_eff    = (len_masked == '0) ? FRAME_COUNT_BITS'(1) : len_masked;

    always_comb
    begin
        if (word_mode_reg == MODE_BYTE)
        begin
            // five spare bits per byte
            pad = PAD_W'(len_eff[2:0] + {len_eff[0], 2'b00});
        end
        else
        begin
            // two spare bits per byte
            pad = {len_eff[1:0], 1'b0};
        end
    end

    assign frame_end = ({1'b0, bytes_seen_reg} + 1'b1) >= {1'b0, len_eff};
    assign header    = (bytes_seen_reg == '0);
    assign gen_low   = generator_reg[2:0];

    // Build codewords
    always_comb
    begin
        if (word_mode_reg == MODE_BYTE)
        begin
            code     = {3'b000, data_byte, crc_rem8(data_byte, gen_low)};
            code_len = CNT_W'(CODE_BITS_BYTE);
        end
        else
        begin
            code     = {data_byte[7:4], crc_rem4(data_byte[7:4], gen_low),
                        data_byte[3:0], crc_rem4(data_byte[3:0], gen_low)};
            code_len = CNT_W'(CODE_BITS_NIBBLE);
        end
    end

    // Prepend header and padding on the first byte of a frame
    assign hdr_shift = code_len + CNT_W'(pad);
    assign hdr_word  = CHUNK_BITS'({5'b00000, pad}) << hdr_shift;

    always_comb
    begin
        chunk.frame_end = frame_end;
        if (header)
        begin
            chunk.bits  = hdr_word | CHUNK_BITS'(code);
            chunk.nbits = hdr_shift + CNT_W'(HEADER_BITS);
        end
        else
        begin
            chunk.bits  = CHUNK_BITS'(code);
            chunk.nbits = code_len;
        end
    end

    assign bytes_seen_next = frame_end ? '0 : bytes_seen_reg + 1'b1;

    // Hold registers and frame position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            generator_reg    <= GEN_RESET;
            word_mode_reg    <= WORD_MODE_RESET;
            frame_length_reg <= FRAME_LEN_RESET;
            bytes_seen_reg   <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                unique case (cfg_index_t'(cfg_index))
                    REG_GENERATOR:    generator_reg    <= cfg_data[GEN_W-1:0];
                    REG_WORD_MODE:    word_mode_reg    <= cfg_data[0];
                    REG_FRAME_LENGTH: frame_length_reg <= cfg_data[FRAME_LEN_W-1:0];
                    default:          ;
                endcase
            end
            if (restart)
            begin
                bytes_seen_reg <= '0;
            end
            else if (accept)
            begin
                bytes_seen_reg <= bytes_seen_next;
            end
        end
    end

    // Frame position stays inside the frame
    a_pos_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        bytes_seen_reg < len_eff)
        else $error("frame position past frame length");

endmodule

@@ design/ccbp_back.sv @@
module ccbp_back
    import ccbp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              restart,
    input  logic              q_empty,
    input  chunk_t            q_data,
    output logic              q_pop,
    output logic              out_valid,
    input  logic              out_pop,
    output logic [DATA_W-1:0] out_byte,
    output logic              out_run_last,
    output logic              out_frame_last
);

    localparam int ACC_W = 32;

    logic [ACC_W-1:0]  acc_reg;
    logic [ACC_W-1:0]  acc_next;
    logic [CNT_W-1:0]  pend_reg;
    logic [CNT_W-1:0]  pend_next;
    logic [CNT_W-1:0]  pend_after;
    logic [CNT_W-1:0]  shift;
    logic              fe_reg;

    logic              valid_reg;
    logic [DATA_W-1:0] byte_reg;
    logic              run_last_reg;
    logic              frame_last_reg;

    logic              out_free;
    logic              emit;
    logic              emit_last;

    // Emit one byte whenever eight bits wait and the output slot frees
    assign out_free  = !valid_reg || out_pop;
    assign emit      = (pend_reg >= CNT_W'(8)) && out_free;
    assign shift     = pend_reg - CNT_W'(8);
    assign emit_last = (pend_reg < CNT_W'(16));
    assign pend_after = emit ? shift : pend_reg;

    // Load the next run once fewer than eight bits remain
    assign q_pop = !q_empty && (pend_after < CNT_W'(8)) && !restart;

    always_comb
    begin
        acc_next  = acc_reg;
        pend_next = pend_after;
        if (q_pop)
        begin
            acc_next  = (acc_reg << q_data.nbits) | ACC_W'(q_data.bits);
            pend_next = pend_after + q_data.nbits;
        end
    end

    // Bit accumulator; bits above the count are stale and ignored
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (q_pop)
        begin
            fe_reg <= q_data.frame_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else if (restart)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            byte_reg       <= 8'(acc_reg >> shift);
            run_last_reg   <= emit_last;
            frame_last_reg <= emit_last && fe_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_pop)
        begin
            valid_reg <= 1'b0;
        end
    end

    assign out_valid      = valid_reg;
    assign out_byte       = byte_reg;
    assign out_run_last   = run_last_reg;
    assign out_frame_last = frame_last_reg;

    // Pending bits never outgrow one full run
    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= CNT_W'(CHUNK_BITS))
        else $error("pending bit count overflow");

    // A frame's final byte is always the last byte of its run
    a_frame_last_run: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && frame_last_reg |-> run_last_reg)
        else $error("frame end without run end");

    // A restart drops all unsent bits
    a_restart_clear: assert property (@(posedge clk) disable iff (!rst_n)
        restart |=> pend_reg == '0)
        else $error("bits survived restart");

endmodule

@@ design/crc_codeword_bit_packer_top.sv @@
// Channel   Dir  Handshake            Words
// input     in   push / full          data_byte
// result    out  empty / pop          out_byte, run_last, frame_last
// config    in   cfg_wr_en            cfg_index, cfg_data
//
// An input byte is taken every cycle while the four-word run queue has room;
// the packer drains one output byte per cycle while results are popped and
// eight bits wait, so the sustained rate is set by the output port. A result
// passes through the run queue, the bit accumulator and the output register.
// Reset clears the registers to their defaults and starts a frame;
// a stalled result holds the packer, which then fills the queue and raises full.
module crc_codeword_bit_packer_top
    import ccbp_pkg::*;
#(
    parameter int FRAME_COUNT_BITS = FRAME_COUNT_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   push,
    output logic                   full,
    input  logic [DATA_W-1:0]      data_byte,
    output logic                   empty,
    input  logic                   pop,
    output logic [DATA_W-1:0]      out_byte,
    output logic                   run_last,
    output logic                   frame_last
);

    chunk_t front_chunk;
    chunk_t q_data;
    logic   restart;
    logic   accept;
    logic   q_full;
    logic   q_empty;
    logic   q_pop;
    logic   out_valid;

    assign accept = push && !q_full;
    assign full   = q_full;
    assign empty  = !out_valid;

    // Classify and encode input bytes
    ccbp_front #(
        .FRAME_COUNT_BITS (FRAME_COUNT_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .data_byte (data_byte),
        .chunk     (front_chunk),
        .restart   (restart)
    );

    // Decouple encoder from packer
    ccbp_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept),
        .wr_data (front_chunk),
        .rd_en   (q_pop),
        .rd_data (q_data),
        .q_full  (q_full),
        .q_empty (q_empty)
    );

    // Pack code bits into bytes
    ccbp_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .restart        (restart),
        .q_empty        (q_empty),
        .q_data         (q_data),
        .q_pop          (q_pop),
        .out_valid      (out_valid),
        .out_pop        (pop),
        .out_byte       (out_byte),
        .out_run_last   (run_last),
        .out_frame_last (frame_last)
    );

endmodule

@@ tb/packer_check.sv @@
`timescale 1ns / 1ps

module packer_check
    import ccbp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   push,
    input  logic                   full,
    input  logic [DATA_W-1:0]      data_byte,
    input  logic                   empty,
    input  logic                   pop,
    input  logic [DATA_W-1:0]      out_byte,
    input  logic                   run_last,
    input  logic                   frame_last,
    output int unsigned            errors,
    output int unsigned            waiting_words
);

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              run_end;
        logic              frame_end;
    } packed_word_t;

    // Output bytes still owed by the block, oldest first
    packed_word_t expected_words[$];
    // Bytes produced by the input byte being encoded
    packed_word_t step_out[$];

    // Register copies
    logic [GEN_W-1:0]       gen_reg;
    logic                   mode_reg;
    logic [FRAME_LEN_W-1:0] flen_reg;

    // Packing state
    logic [31:0]     code_acc;
    int unsigned     code_cnt;
    logic [15:0]     frame_pos;
    int unsigned     fail_count;

    // Long division of the word times x^3 by the generator, top bit forced
    function automatic logic [2:0] crc_remainder(input logic [7:0] word,
                                                 input int unsigned nbits,
                                                 input logic [3:0] poly);
        logic [10:0] rem;
        logic [3:0]  divisor;
        rem = {word, 3'b000};
        divisor = poly | 4'b1000;
        for (int i = nbits + 2; i >= 3; i--)
        begin
            if (rem[i])
            begin
                rem[i -: 4] = rem[i -: 4] ^ divisor;
            end
        end
        return rem[2:0];
    endfunction

    function void restart_frame();
        code_acc = '0;
        code_cnt = 0;
        frame_pos = '0;
    endfunction

    // Append n code bits below the ones already held
    function void add_bits(input logic [31:0] value, input int unsigned n);
        logic [63:0] wide;
        wide = ({32'b0, code_acc} << n) | {32'b0, value};
        code_cnt += n;
        code_acc = 32'(wide & ((64'd1 << code_cnt) - 64'd1));
    endfunction

    // Take whole bytes off the top, at most three per input byte
    function void emit_bytes();
        packed_word_t w;
        int unsigned  sh;
        while (code_cnt >= 8 && step_out.size() < 3)
        begin
            sh = code_cnt - 8;
            w.value = 8'(code_acc >> sh);
            w.run_end = 1'b0;
            w.frame_end = 1'b0;
            step_out.push_back(w);
            code_cnt = sh;
            code_acc = code_acc & ((32'd1 << sh) - 32'd1);
        end
    endfunction

    function void encode_data_byte(input logic [7:0] d);
        logic [15:0]  len;
        int unsigned  nbits;
        int unsigned  pad;
        logic         wrap;
        len = (flen_reg == '0) ? 16'd1 : flen_reg;
        nbits = (mode_reg == MODE_BYTE) ? CODE_BITS_BYTE : CODE_BITS_NIBBLE;
        step_out.delete();

        // Header with the padding count, then the padding itself
        if (frame_pos == '0)
        begin
            pad = ((16 - nbits) * len) % 8;
            add_bits(pad, HEADER_BITS);
            emit_bytes();
            add_bits('0, pad);
            emit_bytes();
        end

        if (mode_reg == MODE_BYTE)
        begin
            add_bits({d, crc_remainder(d, 8, gen_reg)}, CODE_BITS_BYTE);
        end
        else
        begin
            add_bits({d[7:4], crc_remainder({4'b0, d[7:4]}, 4, gen_reg),
                      d[3:0], crc_remainder({4'b0, d[3:0]}, 4, gen_reg)},
                     CODE_BITS_NIBBLE);
        end
        emit_bytes();

        // Advance the frame position
        wrap = ({16'b0, frame_pos} + 32'd1) >= {16'b0, len};
        frame_pos = wrap ? 16'd0 : frame_pos + 16'd1;

        if (step_out.size() > 0)
        begin
            step_out[step_out.size() - 1].run_end = 1'b1;
            step_out[step_out.size() - 1].frame_end = wrap;
        end
        foreach (step_out[i])
        begin
            expected_words.push_back(step_out[i]);
        end
    endfunction

    // A write to a listed register restarts the frame
    function void apply_write(input logic [CFG_INDEX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] value);
        case (idx)
            REG_GENERATOR:
            begin
                gen_reg = value[GEN_W-1:0];
                restart_frame();
            end
            REG_WORD_MODE:
            begin
                mode_reg = value[0];
                restart_frame();
            end
            REG_FRAME_LENGTH:
            begin
                flen_reg = value[FRAME_LEN_W-1:0];
                restart_frame();
            end
            default:
            begin
            end
        endcase
    endfunction

    // Compare the popped word with the oldest expected one
    function void check_word();
        packed_word_t want;
        if (expected_words.size() == 0)
        begin
            $display("%0t: word with none expected: out_byte=%h run_last=%b frame_last=%b",
                     $time, out_byte, run_last, frame_last);
            fail_count++;
            return;
        end
        want = expected_words.pop_front();
        if (out_byte !== want.value)
        begin
            $display("%0t: out_byte expected %h actual %h", $time, want.value, out_byte);
            fail_count++;
        end
        if (run_last !== want.run_end)
        begin
            $display("%0t: run_last expected %b actual %b", $time, want.run_end, run_last);
            fail_count++;
        end
        if (frame_last !== want.frame_end)
        begin
            $display("%0t: frame_last expected %b actual %b",
                     $time, want.frame_end, frame_last);
            fail_count++;
        end
    endfunction

    // Watch all three channels
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gen_reg = GEN_RESET;
            mode_reg = WORD_MODE_RESET;
            flen_reg = FRAME_LEN_RESET;
            restart_frame();
            expected_words.delete();
            fail_count = 0;
            errors <= 0;
            waiting_words <= 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                check_word();
            end
            if (cfg_wr_en)
            begin
                apply_write(cfg_index, cfg_data);
            end
            if (push && !full)
            begin
                encode_data_byte(data_byte);
            end
            errors <= fail_count;
            waiting_words <= expected_words.size();
        end
    end

endmodule

@@ tb/tb_crc_codeword_bit_packer_top.sv @@
`timescale 1ns / 1ps

module tb_crc_codeword_bit_packer_top;
    import ccbp_pkg::*;

    localparam int unsigned TIMEOUT_CYCLES = 200000;
    localparam int unsigned SETTLE_CYCLES  = 16;
    localparam int unsigned RX_HOLD_CYCLES = 150;
    localparam int unsigned SEG_ITEMS      = 52;

    // Index past the register list: accepted but changes nothing
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   push;
    logic                   full;
    logic [DATA_W-1:0]      data_byte;
    logic                   empty;
    logic                   pop;
    logic [DATA_W-1:0]      out_byte;
    logic                   run_last;
    logic                   frame_last;
    logic                   hold_request;

    int unsigned errors;
    int unsigned waiting_words;
    int unsigned tx_idle_pct;
    int unsigned rx_idle_pct;

    int unsigned tx_pcts[3] = '{14, 69, 0};
    int unsigned rx_pcts[3] = '{69, 14, 0};

    crc_codeword_bit_packer_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .push       (push),
        .full       (full),
        .data_byte  (data_byte),
        .empty      (empty),
        .pop        (pop),
        .out_byte   (out_byte),
        .run_last   (run_last),
        .frame_last (frame_last)
    );

    packer_check u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .push          (push),
        .full          (full),
        .data_byte     (data_byte),
        .empty         (empty),
        .pop           (pop),
        .out_byte      (out_byte),
        .run_last      (run_last),
        .frame_last    (frame_last),
        .errors        (errors),
        .waiting_words (waiting_words)
    );

    always #5 clk = ~clk;

    // Give up if the run hangs
    initial
    begin
        repeat (TIMEOUT_CYCLES) @(posedge clk);
        $display("tb_crc_codeword_bit_packer_top: done, errors");
        $finish;
    end

    // Result side: random pops, plus one long hold when asked
    initial
    begin
        int unsigned hold_left;
        logic        hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        pop = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else if (hold_request && !hold_done)
            begin
                hold_left = RX_HOLD_CYCLES;
                hold_done = 1'b1;
                pop <= 1'b0;
            end
            else
            begin
                pop <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    // Offer one word and hold it until taken; push stays high afterwards
    task automatic send_byte(input logic [DATA_W-1:0] d);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        data_byte <= d;
        @(posedge clk);
        while (full)
        begin
            @(posedge clk);
        end
    endtask

    // Stop sending until every expected word is out, then let the block settle
    task automatic wait_drained();
        push <= 1'b0;
        @(posedge clk);
        while (waiting_words != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Leaves the write enable high; the caller drops it
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
    endtask

    task automatic load_setup(input logic [CFG_DATA_W-1:0] gen_word,
                              input logic [CFG_DATA_W-1:0] mode_word,
                              input logic [CFG_DATA_W-1:0] len_word);
        wait_drained();
        write_reg(REG_GENERATOR, gen_word);
        write_reg(REG_WORD_MODE, mode_word);
        write_reg(REG_FRAME_LENGTH, len_word);
        cfg_wr_en <= 1'b0;
    endtask

    // Mostly short frames, now and then a long one or an extreme
    task automatic load_random_setup();
        logic [CFG_DATA_W-1:0] len;
        int unsigned           pick;
        pick = $urandom_range(0, 9);
        case (pick)
            0:       len = '0;
            1:       len = '1;
            2:       len = 16'($urandom_range(7, 40));
            default: len = 16'($urandom_range(1, 6));
        endcase
        load_setup(16'($urandom), 16'($urandom), len);
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_GENERATOR;
        cfg_data = '0;
        push = 1'b0;
        data_byte = '0;
        hold_request = 1'b0;
        tx_idle_pct = tx_pcts[0];
        rx_idle_pct = rx_pcts[0];

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: byte mode, one-byte frames
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h80);
        send_byte(8'h01);
        send_byte(8'h5A);

        // Generator top bit clear, nibble mode, frame length zero
        load_setup(16'hFFF3, {15'h7FFF, MODE_NIBBLE}, 16'h0000);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'hF0);
        send_byte(8'h0F);

        // Smallest legal generator, byte mode, two frames of three
        load_setup(16'h0008, {15'h0000, MODE_BYTE}, 16'd3);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'hC3);
        send_byte(8'h3C);
        send_byte(8'h7E);
        send_byte(8'h81);

        // Largest generator and frame; an unlisted write must not break the frame
        load_setup(16'h000F, {15'h0000, MODE_NIBBLE}, 16'hFFFF);
        send_byte(8'hA5);
        send_byte(8'h5A);
        send_byte(8'hFF);
        wait_drained();
        write_reg(REG_UNUSED, 16'hFFFF);
        cfg_wr_en <= 1'b0;
        send_byte(8'h01);
        send_byte(8'hFE);

        // Random part: three idling regimes, two setups each
        for (int phase = 0; phase < 3; phase++)
        begin
            tx_idle_pct = tx_pcts[phase];
            rx_idle_pct = rx_pcts[phase];
            for (int seg = 0; seg < 2; seg++)
            begin
                load_random_setup();
                if (phase == 2 && seg == 1)
                begin
                    hold_request <= 1'b1;
                end
                for (int n = 0; n < SEG_ITEMS; n++)
                begin
                    send_byte(8'($urandom_range(0, 255)));
                end
            end
        end

        wait_drained();
        if (errors == 0 && waiting_words == 0)
        begin
            $display("tb_crc_codeword_bit_packer_top: done, clean");
        end
        else
        begin
            $display("tb_crc_codeword_bit_packer_top: done, errors");
        end
        $finish;
    end

endmodule

@@ files.f @@
design/ccbp_pkg.sv
design/ccbp_queue.sv
design/ccbp_front.sv
design/ccbp_back.sv
design/crc_codeword_bit_packer_top.sv
tb/packer_check.sv
tb/tb_crc_codeword_bit_packer_top.sv
